// File: rtl/sprite_place_and_tint_blit_defines.svh
// assertion macros for the sprite blitter checker
`ifndef SPRITE_PLACE_AND_TINT_BLIT_DEFINES_SVH
`define SPRITE_PLACE_AND_TINT_BLIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define SPRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprite blitter check failed");

// next-cycle implication, masked during reset
`define SPRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprite blitter check failed");

// next-cycle implication, live through reset
`define SPRB_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sprite blitter reset check failed");

`endif

// File: rtl/sprb_pkg.sv
// shared types and constants for the sprite place and tint blitter
package sprb_pkg;

  localparam int COORD_BITS  = 8;
  localparam int OFF_BITS    = COORD_BITS + 1;
  localparam int SUM_BITS    = ((OFF_BITS > 9) ? OFF_BITS : 9) + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 32;

  localparam logic [2:0] REG_VIEW_COLS         = 3'd0;
  localparam logic [2:0] REG_VIEW_ROWS         = 3'd1;
  localparam logic [2:0] REG_SPRITE_COLS       = 3'd2;
  localparam logic [2:0] REG_SPRITE_ROWS       = 3'd3;
  localparam logic [2:0] REG_PLACE_MODE        = 3'd4;
  localparam logic [2:0] REG_RENDER_ORIGINAL   = 3'd5;
  localparam logic [2:0] REG_TRANSPARENT_BLACK = 3'd6;
  localparam logic [2:0] REG_TINT_COLOR        = 3'd7;

  localparam logic [2:0] PLACE_BOUNCE = 3'd0;
  localparam logic [2:0] PLACE_CENTER = 3'd1;
  localparam logic [2:0] PLACE_LEFT   = 3'd2;
  localparam logic [2:0] PLACE_RIGHT  = 3'd3;
  localparam logic [2:0] PLACE_TOP    = 3'd4;
  localparam logic [2:0] PLACE_BOTTOM = 3'd5;

  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [7:0]  KEY_BRIGHT  = 8'd240;
  localparam logic [7:0]  KEY_DARK    = 8'd15;
  localparam logic [7:0]  FULL_SCALE  = 8'd255;
  localparam logic [2:0]  BOUNCE_TICK = 3'd0;

  localparam logic [7:0]  RST_VIEW_COLS   = 8'd45;
  localparam logic [7:0]  RST_VIEW_ROWS   = 8'd35;
  localparam logic [7:0]  RST_SPRITE_COLS = 8'd16;
  localparam logic [7:0]  RST_SPRITE_ROWS = 8'd16;
  localparam logic [23:0] RST_TINT_COLOR  = 24'hFFFFFF;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic       write_enable;
    logic [7:0] dest_x;
    logic [7:0] dest_y;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_t;

  typedef struct packed {
    logic [7:0]  view_cols;
    logic [7:0]  view_rows;
    logic [7:0]  sprite_cols;
    logic [7:0]  sprite_rows;
    logic [2:0]  place_mode;
    logic        render_original;
    logic        transparent_black;
    logic [23:0] tint_color;
  } cfg_t;

  // classified work handed from front to back
  typedef struct packed {
    logic       write_enable;
    logic [7:0] dest_x;
    logic [7:0] dest_y;
    logic [7:0] chan_r;
    logic [7:0] chan_g;
    logic [7:0] chan_b;
    logic [7:0] factor;
  } job_t;

endpackage

// File: rtl/sprb_regs.sv
// configuration register file behind the apb port
module sprb_regs
  import sprb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_cols         <= RST_VIEW_COLS;
      cfg.view_rows         <= RST_VIEW_ROWS;
      cfg.sprite_cols       <= RST_SPRITE_COLS;
      cfg.sprite_rows       <= RST_SPRITE_ROWS;
      cfg.place_mode        <= PLACE_BOUNCE;
      cfg.render_original   <= 1'b0;
      cfg.transparent_black <= 1'b0;
      cfg.tint_color        <= RST_TINT_COLOR;
    end else if (wr) begin
      case (index)
        REG_VIEW_COLS:         cfg.view_cols         <= pwdata[7:0];
        REG_VIEW_ROWS:         cfg.view_rows         <= pwdata[7:0];
        REG_SPRITE_COLS:       cfg.sprite_cols       <= pwdata[7:0];
        REG_SPRITE_ROWS:       cfg.sprite_rows       <= pwdata[7:0];
        REG_PLACE_MODE:        cfg.place_mode        <= pwdata[2:0];
        REG_RENDER_ORIGINAL:   cfg.render_original   <= pwdata[0];
        REG_TRANSPARENT_BLACK: cfg.transparent_black <= pwdata[0];
        REG_TINT_COLOR:        cfg.tint_color        <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_VIEW_COLS:         prdata = DATA_BITS'(cfg.view_cols);
      REG_VIEW_ROWS:         prdata = DATA_BITS'(cfg.view_rows);
      REG_SPRITE_COLS:       prdata = DATA_BITS'(cfg.sprite_cols);
      REG_SPRITE_ROWS:       prdata = DATA_BITS'(cfg.sprite_rows);
      REG_PLACE_MODE:        prdata = DATA_BITS'(cfg.place_mode);
      REG_RENDER_ORIGINAL:   prdata = DATA_BITS'(cfg.render_original);
      REG_TRANSPARENT_BLACK: prdata = DATA_BITS'(cfg.transparent_black);
      REG_TINT_COLOR:        prdata = DATA_BITS'(cfg.tint_color);
      default:               prdata = '0;
    endcase
  end

endmodule

// File: rtl/sprb_front.sv
// front end: frame offset state, placement, color key and screen clipping
module sprb_front
  import sprb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  input  in_t  in_data,
  input  logic queue_full,
  output logic in_ready,
  output logic push,
  output job_t push_data
);

  typedef struct packed {
    logic [OFF_BITS-1:0] pos;
    logic                back;
  } axis_t;

  logic [2:0]          frame_phase;
  logic [OFF_BITS-1:0] bounce_x;
  logic [OFF_BITS-1:0] bounce_y;
  logic                step_left;
  logic                step_up;
  logic [OFF_BITS-1:0] frame_offset_x;
  logic [OFF_BITS-1:0] frame_offset_y;

  axis_t               axis_x_next;
  axis_t               axis_y_next;
  logic [OFF_BITS-1:0] half_x, half_y, full_x, full_y;
  logic [OFF_BITS-1:0] frame_offset_x_next;
  logic [OFF_BITS-1:0] frame_offset_y_next;
  logic                do_bounce;
  logic                accept;
  logic [SUM_BITS-1:0] sx, sy;
  logic                skip, on_screen;

  function automatic logic [SUM_BITS-1:0] sext(input logic [OFF_BITS-1:0] v);
    return {{(SUM_BITS-OFF_BITS){v[OFF_BITS-1]}}, v};
  endfunction

  function automatic axis_t bounce_step(input logic [OFF_BITS-1:0] pos, input logic back,
                                        input logic [7:0] disp, input logic [7:0] img);
    logic [SUM_BITS-1:0] nxt;
    logic [SUM_BITS-1:0] disp_w;
    logic [SUM_BITS-1:0] img_w;
    axis_t               r;
    disp_w = SUM_BITS'(disp);
    img_w  = SUM_BITS'(img);
    nxt    = back ? (sext(pos) - SUM_BITS'(1)) : (sext(pos) + SUM_BITS'(1));
    if (nxt[SUM_BITS-1]) begin
      r.pos  = '0;
      r.back = 1'b0;
    end else if ($signed(nxt + img_w) > $signed(disp_w)) begin
      r.pos  = OFF_BITS'(disp_w - img_w);
      r.back = 1'b1;
    end else begin
      r.pos  = OFF_BITS'(nxt);
      r.back = back;
    end
    return r;
  endfunction

  function automatic logic [OFF_BITS-1:0] gap(input logic [7:0] disp, input logic [7:0] img,
                                              input logic halve);
    logic [8:0] diff;
    diff = {1'b0, disp} - {1'b0, img};
    if (disp <= img) begin
      return '0;
    end
    return halve ? OFF_BITS'(diff >> 1) : OFF_BITS'(diff);
  endfunction

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  assign push      = accept;
  assign do_bounce = (cfg.place_mode == PLACE_BOUNCE) && (frame_phase == BOUNCE_TICK);

  assign axis_x_next = bounce_step(bounce_x, step_left, cfg.view_cols, cfg.sprite_cols);
  assign axis_y_next = bounce_step(bounce_y, step_up, cfg.view_rows, cfg.sprite_rows);
  assign half_x = gap(cfg.view_cols, cfg.sprite_cols, 1'b1);
  assign half_y = gap(cfg.view_rows, cfg.sprite_rows, 1'b1);
  assign full_x = gap(cfg.view_cols, cfg.sprite_cols, 1'b0);
  assign full_y = gap(cfg.view_rows, cfg.sprite_rows, 1'b0);

  always_comb begin
    case (cfg.place_mode)
      PLACE_BOUNCE: begin
        frame_offset_x_next = do_bounce ? axis_x_next.pos : bounce_x;
        frame_offset_y_next = do_bounce ? axis_y_next.pos : bounce_y;
      end
      PLACE_CENTER: begin
        frame_offset_x_next = half_x;
        frame_offset_y_next = half_y;
      end
      PLACE_LEFT: begin
        frame_offset_x_next = '0;
        frame_offset_y_next = half_y;
      end
      PLACE_RIGHT: begin
        frame_offset_x_next = full_x;
        frame_offset_y_next = half_y;
      end
      PLACE_TOP: begin
        frame_offset_x_next = half_x;
        frame_offset_y_next = '0;
      end
      PLACE_BOTTOM: begin
        frame_offset_x_next = half_x;
        frame_offset_y_next = full_y;
      end
      default: begin
        frame_offset_x_next = '0;
        frame_offset_y_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase    <= '0;
      bounce_x       <= '0;
      bounce_y       <= '0;
      step_left      <= 1'b0;
      step_up        <= 1'b0;
      frame_offset_x <= '0;
      frame_offset_y <= '0;
    end else if (accept && in_data.mode == MODE_FRAME) begin
      frame_phase    <= frame_phase + 3'd1;
      frame_offset_x <= frame_offset_x_next;
      frame_offset_y <= frame_offset_y_next;
      if (do_bounce) begin
        bounce_x  <= axis_x_next.pos;
        bounce_y  <= axis_y_next.pos;
        step_left <= axis_x_next.back;
        step_up   <= axis_y_next.back;
      end
    end
  end

  // pixel classification
  assign sx = sext(frame_offset_x) + SUM_BITS'(in_data.pixel_x);
  assign sy = sext(frame_offset_y) + SUM_BITS'(in_data.pixel_y);
  assign skip = cfg.transparent_black ? (in_data.gray <= KEY_DARK)
                                      : (in_data.gray >= KEY_BRIGHT);
  assign on_screen = !sx[SUM_BITS-1] && (sx < SUM_BITS'(cfg.view_cols)) &&
                     !sy[SUM_BITS-1] && (sy < SUM_BITS'(cfg.view_rows));

  // original colour rides through the back end with a full-scale factor
  always_comb begin
    push_data = '0;
    if (in_data.mode == MODE_PIXEL && !skip && on_screen) begin
      push_data.write_enable = 1'b1;
      push_data.dest_x       = sx[7:0];
      push_data.dest_y       = sy[7:0];
      if (cfg.render_original) begin
        push_data.chan_r = in_data.red;
        push_data.chan_g = in_data.green;
        push_data.chan_b = in_data.blue;
        push_data.factor = FULL_SCALE;
      end else begin
        push_data.chan_r = cfg.tint_color[23:16];
        push_data.chan_g = cfg.tint_color[15:8];
        push_data.chan_b = cfg.tint_color[7:0];
        push_data.factor = FULL_SCALE - in_data.gray;
      end
    end
  end

endmodule

// File: rtl/sprb_queue.sv
// short job queue between front and back
module sprb_queue
  import sprb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop_ready,
  output logic pop_valid,
  output job_t pop_data
);

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 pop;

  assign full      = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_BITS+1)'(1);
        2'b01:   count <= count - (QPTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/sprb_back.sv
// back end: tint multiply, divide by 255 and output register
module sprb_back
  import sprb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  job_t job,
  output logic job_ready,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef struct packed {
    logic        write_enable;
    logic [7:0]  dest_x;
    logic [7:0]  dest_y;
    logic [15:0] prod_r;
    logic [15:0] prod_g;
    logic [15:0] prod_b;
  } prod_t;

  logic  s1_valid;
  prod_t s1;
  logic  out_adv;

  // exact floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  assign out_adv   = !out_valid || out_ready;
  assign job_ready = !s1_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_ready) begin
        s1_valid <= job_valid;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      s1.write_enable <= job.write_enable;
      s1.dest_x       <= job.dest_x;
      s1.dest_y       <= job.dest_y;
      s1.prod_r       <= 16'(job.chan_r) * 16'(job.factor);
      s1.prod_g       <= 16'(job.chan_g) * 16'(job.factor);
      s1.prod_b       <= 16'(job.chan_b) * 16'(job.factor);
    end
    if (out_adv && s1_valid) begin
      out_data.write_enable <= s1.write_enable;
      out_data.dest_x       <= s1.dest_x;
      out_data.dest_y       <= s1.dest_y;
      out_data.out_red      <= div255(s1.prod_r);
      out_data.out_green    <= div255(s1.prod_g);
      out_data.out_blue     <= div255(s1.prod_b);
    end
  end

endmodule

// File: rtl/sprite_place_and_tint_blit.sv
// top level of the sprite place and tint blitter
//
//   channel  direction  handshake          payload
//   cfg      in         psel/penable/...   pwdata, paddr, prdata
//   in       in         in_valid/in_ready  in_data (in_t)
//   out      out        out_valid/out_ready out_data (out_t)
//
// one item per clock sustained while out_ready stays high; a result passes the queue,
// the multiply stage and the divide stage and leaves from the output register
// a four-entry queue decouples the front from back-end output stalls
// in_ready drops only when the queue is full
// reset restores register defaults and clears offset, bounce and phase state
module sprite_place_and_tint_blit
  import sprb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data
);

  cfg_t cfg;
  logic push;
  job_t push_data;
  logic queue_full;
  logic job_valid;
  logic job_ready;
  job_t job;

  sprb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sprb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .queue_full (queue_full),
    .in_ready   (in_ready),
    .push       (push),
    .push_data  (push_data)
  );

  sprb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop_ready (job_ready),
    .pop_valid (job_valid),
    .pop_data  (job)
  );

  sprb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/sprb_checker.sv
// port-level checker for the sprite blitter, bound to the top level
`include "sprite_place_and_tint_blit_defines.svh"

module sprb_checker
  import sprb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic pready,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `SPRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `SPRB_ASSERT_NOW(a_pready_high, 1'b1, pready)
  `SPRB_ASSERT_NOW(a_no_write_zero, out_valid && !out_data.write_enable, out_data == '0)
  `SPRB_ASSERT_RESET(a_reset_empty, rst, !out_valid && in_ready)

endmodule

bind sprite_place_and_tint_blit sprb_checker u_sprb_checker (.*);
